// ===== src/mlp_pkg.sv =====
// Shared types, constants and the exp table for the perceptron inference block.
// Used by mlp_inference_leaky_softmax and its testbench.
package mlp_pkg;

  localparam int InputNodes     = 400;
  localparam int HiddenOneNodes = 12;
  localparam int HiddenTwoNodes = 12;
  localparam int OutputNodes    = 4;

  localparam int IndexW  = 13;
  localparam int ValueW  = 16;
  localparam int PixelW  = 8;
  localparam int ClassW  = 2;
  localparam int ProbW   = 16;

  localparam int MulAW   = 34;
  localparam int MulBW   = 18;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 56;
  localparam int LeakQ16 = 3277;
  localparam int Log2eQ16 = 94548;
  localparam int ExpW    = 17;
  localparam int DivW    = 33;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_PIXEL  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_FIN, S_LEAK, S_LSTORE, S_ZMAX,
    S_EXP_MUL, S_EXP_INT, S_EXP_END, S_DIV_INIT, S_DIV, S_DIV_END, S_OUT
  } state_e;

  // 2^(-k/16) in units of 1/65536.
  function automatic logic [ExpW-1:0] pow2_lut(input logic [4:0] k);
    logic [ExpW-1:0] r;
    begin
      case (k)
        5'd0:  r = 17'd65536;
        5'd1:  r = 17'd62757;
        5'd2:  r = 17'd60097;
        5'd3:  r = 17'd57549;
        5'd4:  r = 17'd55109;
        5'd5:  r = 17'd52773;
        5'd6:  r = 17'd50535;
        5'd7:  r = 17'd48393;
        5'd8:  r = 17'd46341;
        5'd9:  r = 17'd44376;
        5'd10: r = 17'd42495;
        5'd11: r = 17'd40693;
        5'd12: r = 17'd38968;
        5'd13: r = 17'd37316;
        5'd14: r = 17'd35734;
        5'd15: r = 17'd34219;
        5'd16: r = 17'd32768;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/mlp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mlp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/mlp_inference_leaky_softmax.sv =====
// Perceptron inference with leaky ReLU hidden layers and a softmax output.
// A last pixel request runs the network on one shared multiplier: S_RD, S_MUL and S_ACC per
// multiply-accumulate term, S_FIN, S_LEAK and S_LSTORE per hidden and S_FIN per output node;
// then per class S_ZMAX for the maximum, S_EXP_MUL, S_EXP_INT and S_EXP_END for exp,
// S_DIV_INIT, S_DIV and S_DIV_END for the serial divider and S_OUT per result. Reset clears
// control state and the bias store; the receiver cannot stall results.
module mlp_inference_leaky_softmax #(
  parameter int InNodes  = mlp_pkg::InputNodes,
  parameter int H1Nodes  = mlp_pkg::HiddenOneNodes,
  parameter int H2Nodes  = mlp_pkg::HiddenTwoNodes,
  parameter int OutNodes = mlp_pkg::OutputNodes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op_i,
  input  logic [mlp_pkg::IndexW-1:0]  index_i,
  input  logic signed [mlp_pkg::ValueW-1:0] weight_value_i,
  input  logic [mlp_pkg::PixelW-1:0]  pixel_i,
  input  logic                        last_pixel_i,
  output logic                        result_valid_o,
  output logic [mlp_pkg::ClassW-1:0]  class_index_o,
  output logic [mlp_pkg::ProbW-1:0]   probability_o,
  output logic [mlp_pkg::ClassW-1:0]  best_class_o,
  output logic                        last_o
);
  // Store layout, all derived from the layer sizes.
  localparam int WL2Base = InNodes * H1Nodes;
  localparam int WL3Base = WL2Base + H1Nodes * H2Nodes;
  localparam int WTotal  = WL3Base + H2Nodes * OutNodes;
  localparam int BTotal  = H1Nodes + H2Nodes + OutNodes;
  localparam int HTotal  = H1Nodes + H2Nodes;
  localparam int WAddrW  = (WTotal > 1) ? $clog2(WTotal) : 1;
  localparam int PAddrW  = (InNodes > 1) ? $clog2(InNodes) : 1;
  localparam int BIdxW   = (BTotal > 1) ? $clog2(BTotal) : 1;
  localparam int HIdxW   = (HTotal > 1) ? $clog2(HTotal) : 1;
  localparam int ZIdxW   = (OutNodes > 1) ? $clog2(OutNodes) : 1;
  localparam int MaxFan  = (InNodes > H1Nodes) ?
                           ((InNodes > H2Nodes) ? InNodes : H2Nodes) :
                           ((H1Nodes > H2Nodes) ? H1Nodes : H2Nodes);
  localparam int MaxNode = (H1Nodes > H2Nodes) ?
                           ((H1Nodes > OutNodes) ? H1Nodes : OutNodes) :
                           ((H2Nodes > OutNodes) ? H2Nodes : OutNodes);
  localparam int TermW   = $clog2(MaxFan + 1);
  localparam int NodeW   = $clog2(MaxNode + 1);
  localparam int SumW    = mlp_pkg::ExpW + $clog2(OutNodes + 1);
  localparam int AccW    = mlp_pkg::AccW;
  localparam int ProdW   = mlp_pkg::ProdW;
  localparam int ExpW    = mlp_pkg::ExpW;
  localparam int DivW    = mlp_pkg::DivW;

  mlp_pkg::state_e state_q, state_d;

  logic [1:0]       layer_q, layer_d;
  logic [NodeW-1:0] node_q, node_d;
  logic [TermW-1:0] term_q, term_d;
  logic [5:0]       cnt_q, cnt_d;

  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [31:0]      v_q, v_d;
  logic signed [31:0]      zmax_q, zmax_d;
  logic [ExpW-1:0]         tk_q, tk_d;
  logic [4:0]              shift_q, shift_d;
  logic                    zero_q, zero_d;
  logic [SumW-1:0]         sum_q, sum_d;
  logic [DivW-1:0]         quo_q, quo_d;
  logic [SumW-1:0]         rem_q, rem_d;
  logic [ZIdxW-1:0]        best_q, best_d;
  logic [ExpW-1:0]         bestv_q, bestv_d;

  logic signed [mlp_pkg::ValueW-1:0] bias_q [BTotal];
  logic signed [31:0]                hid_q  [HTotal];
  logic signed [31:0]                z_q    [OutNodes];
  logic [ExpW-1:0]                   exp_q  [OutNodes];
  logic [ExpW-1:0]                   quot_q [OutNodes];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != mlp_pkg::S_IDLE);

  // Stores written by load and pixel requests.
  logic w_we, p_we, b_we;
  logic [mlp_pkg::ValueW-1:0] w_rdata;
  logic [mlp_pkg::PixelW-1:0] p_rdata;
  logic [WAddrW-1:0] w_raddr;
  logic [PAddrW-1:0] p_raddr;

  assign w_we = accept && (op_i == mlp_pkg::OP_WEIGHT) && (32'(index_i) < WTotal);
  assign b_we = accept && (op_i == mlp_pkg::OP_BIAS)   && (32'(index_i) < BTotal);
  assign p_we = accept && (op_i == mlp_pkg::OP_PIXEL)  && (32'(index_i) < InNodes);

  mlp_ram #(.Width(mlp_pkg::ValueW), .Depth(WTotal), .AddrW(WAddrW)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (WAddrW'(index_i)),
    .wdata_i (weight_value_i),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  mlp_ram #(.Width(mlp_pkg::PixelW), .Depth(InNodes), .AddrW(PAddrW)) u_pram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (PAddrW'(index_i)),
    .wdata_i (pixel_i),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BTotal; b++) begin
        bias_q[b] <= '0;
      end
    end else if (b_we) begin
      bias_q[BIdxW'(index_i)] <= weight_value_i;
    end
  end

  // Per-layer geometry of the current node.
  int fan_in, nodes, w_addr_int, b_idx_int, h_rd_int, h_wr_int;
  always_comb begin
    case (layer_q)
      2'd0: begin
        fan_in     = InNodes;
        nodes      = H1Nodes;
        w_addr_int = int'(term_q) * H1Nodes + int'(node_q);
        b_idx_int  = int'(node_q);
        h_rd_int   = 0;
        h_wr_int   = int'(node_q);
      end
      2'd1: begin
        fan_in     = H1Nodes;
        nodes      = H2Nodes;
        w_addr_int = WL2Base + int'(term_q) * H2Nodes + int'(node_q);
        b_idx_int  = H1Nodes + int'(node_q);
        h_rd_int   = int'(term_q);
        h_wr_int   = H1Nodes + int'(node_q);
      end
      default: begin
        fan_in     = H2Nodes;
        nodes      = OutNodes;
        w_addr_int = WL3Base + int'(term_q) * OutNodes + int'(node_q);
        b_idx_int  = H1Nodes + H2Nodes + int'(node_q);
        h_rd_int   = H1Nodes + int'(term_q);
        h_wr_int   = 0;
      end
    endcase
  end

  assign w_raddr = WAddrW'(w_addr_int);
  assign p_raddr = PAddrW'(term_q);

  // Shared multiplier operand selection.
  logic signed [mlp_pkg::MulAW-1:0] mul_a;
  logic signed [mlp_pkg::MulBW-1:0] mul_b;
  logic signed [32:0]               zdiff;
  logic [ZIdxW-1:0]                 cls;
  logic [ExpW-1:0]                  tk_next;
  logic [4:0]                       k_idx;

  assign cls     = ZIdxW'(node_q);
  assign zdiff   = 33'(zmax_q) - 33'(z_q[cls]);
  assign k_idx   = {1'b0, prod_q[31:28]};
  assign tk_next = mlp_pkg::pow2_lut(k_idx + 5'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      mlp_pkg::S_MUL: begin
        // Weights are signed Q3.12 and must be sign extended.
        mul_b = mlp_pkg::MulBW'($signed(w_rdata));
        if (layer_q == 2'd0) begin
          mul_a = mlp_pkg::MulAW'({1'b0, p_rdata} * 17'd257);
        end else begin
          mul_a = mlp_pkg::MulAW'(hid_q[HIdxW'(h_rd_int)]);
        end
      end
      mlp_pkg::S_LEAK: begin
        mul_a = mlp_pkg::MulAW'(v_q);
        mul_b = mlp_pkg::MulBW'(mlp_pkg::LeakQ16);
      end
      mlp_pkg::S_EXP_MUL: begin
        mul_a = mlp_pkg::MulAW'(zdiff);
        mul_b = mlp_pkg::MulBW'(mlp_pkg::Log2eQ16);
      end
      mlp_pkg::S_EXP_INT: begin
        mul_a = mlp_pkg::MulAW'({1'b0, mlp_pkg::pow2_lut(k_idx) - tk_next});
        mul_b = mlp_pkg::MulBW'({6'b0, prod_q[27:16]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Bias add, floor shift by 12 and saturation to 32 bits.
  logic signed [AccW-1:0] biased, shifted;
  logic signed [31:0]     sat_v;
  assign biased  = acc_q + (AccW'(bias_q[BIdxW'(b_idx_int)]) <<< 16);
  assign shifted = biased >>> 12;
  always_comb begin
    if (shifted > AccW'(64'sh7FFF_FFFF)) begin
      sat_v = 32'sh7FFF_FFFF;
    end else if (shifted < -AccW'(64'sh8000_0000)) begin
      sat_v = -32'sh8000_0000;
    end else begin
      sat_v = shifted[31:0];
    end
  end

  logic [ExpW-1:0]   m_val, e_val;
  logic [SumW:0]     rem_sh;
  logic              div_ge;
  assign m_val  = tk_q - ExpW'(prod_q[ProdW-1:12]);
  assign e_val  = zero_q ? '0 : (m_val >> shift_q);
  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign div_ge = (rem_sh >= {1'b0, sum_q});

  logic node_last, term_last;
  assign node_last = (int'(node_q) == nodes - 1);
  assign term_last = (int'(term_q) == fan_in - 1);

  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    node_d  = node_q;
    term_d  = term_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    v_d     = v_q;
    zmax_d  = zmax_q;
    tk_d    = tk_q;
    shift_d = shift_q;
    zero_d  = zero_q;
    sum_d   = sum_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    best_d  = best_q;
    bestv_d = bestv_q;
    case (state_q)
      mlp_pkg::S_IDLE: begin
        if (accept && (op_i == mlp_pkg::OP_PIXEL) && last_pixel_i) begin
          layer_d = 2'd0;
          node_d  = '0;
          term_d  = '0;
          acc_d   = '0;
          state_d = mlp_pkg::S_RD;
        end
      end
      mlp_pkg::S_RD: state_d = mlp_pkg::S_MUL;
      mlp_pkg::S_MUL: begin
        prod_d  = mul_a * mul_b;
        state_d = mlp_pkg::S_ACC;
      end
      mlp_pkg::S_ACC: begin
        acc_d = acc_q + AccW'(prod_q);
        if (term_last) begin
          state_d = mlp_pkg::S_FIN;
        end else begin
          term_d  = term_q + 1'b1;
          state_d = mlp_pkg::S_RD;
        end
      end
      mlp_pkg::S_FIN: begin
        v_d = sat_v;
        if (layer_q == 2'd2) begin
          acc_d  = '0;
          term_d = '0;
          if (node_last) begin
            node_d  = '0;
            state_d = mlp_pkg::S_ZMAX;
          end else begin
            node_d  = node_q + 1'b1;
            state_d = mlp_pkg::S_RD;
          end
        end else begin
          state_d = mlp_pkg::S_LEAK;
        end
      end
      mlp_pkg::S_LEAK: begin
        prod_d  = mul_a * mul_b;
        state_d = mlp_pkg::S_LSTORE;
      end
      mlp_pkg::S_LSTORE: begin
        acc_d   = '0;
        term_d  = '0;
        state_d = mlp_pkg::S_RD;
        if (node_last) begin
          node_d  = '0;
          layer_d = layer_q + 2'd1;
        end else begin
          node_d = node_q + 1'b1;
        end
      end
      mlp_pkg::S_ZMAX: begin
        if (node_q == '0 || z_q[cls] > zmax_q) begin
          zmax_d = z_q[cls];
        end
        if (node_last) begin
          node_d  = '0;
          sum_d   = '0;
          state_d = mlp_pkg::S_EXP_MUL;
        end else begin
          node_d = node_q + 1'b1;
        end
      end
      mlp_pkg::S_EXP_MUL: begin
        prod_d  = mul_a * mul_b;
        state_d = mlp_pkg::S_EXP_INT;
      end
      mlp_pkg::S_EXP_INT: begin
        // Integer part of the exponent picks the shift; table step interpolates.
        zero_d  = (prod_q[ProdW-1:32] >= (ProdW - 32)'(17));
        shift_d = prod_q[36:32];
        tk_d    = mlp_pkg::pow2_lut(k_idx);
        prod_d  = mul_a * mul_b;
        state_d = mlp_pkg::S_EXP_END;
      end
      mlp_pkg::S_EXP_END: begin
        sum_d = sum_q + SumW'(e_val);
        if (node_last) begin
          node_d  = '0;
          state_d = mlp_pkg::S_DIV_INIT;
        end else begin
          node_d  = node_q + 1'b1;
          state_d = mlp_pkg::S_EXP_MUL;
        end
      end
      mlp_pkg::S_DIV_INIT: begin
        quo_d   = {exp_q[cls], 16'b0};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = mlp_pkg::S_DIV;
      end
      mlp_pkg::S_DIV: begin
        if (div_ge) begin
          rem_d = SumW'(rem_sh - {1'b0, sum_q});
        end else begin
          rem_d = SumW'(rem_sh);
        end
        quo_d = {quo_q[DivW-2:0], div_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivW - 1)) begin
          state_d = mlp_pkg::S_DIV_END;
        end
      end
      mlp_pkg::S_DIV_END: begin
        if (node_q == '0 || quo_q[ExpW-1:0] > bestv_q) begin
          best_d  = cls;
          bestv_d = quo_q[ExpW-1:0];
        end
        if (node_last) begin
          node_d  = '0;
          state_d = mlp_pkg::S_OUT;
        end else begin
          node_d  = node_q + 1'b1;
          state_d = mlp_pkg::S_DIV_INIT;
        end
      end
      mlp_pkg::S_OUT: begin
        if (node_last) begin
          node_d  = '0;
          state_d = mlp_pkg::S_IDLE;
        end else begin
          node_d = node_q + 1'b1;
        end
      end
      default: state_d = mlp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlp_pkg::S_IDLE;
      layer_q <= '0;
      node_q  <= '0;
      term_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      node_q  <= node_d;
      term_q  <= term_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers and small node stores.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    v_q     <= v_d;
    zmax_q  <= zmax_d;
    tk_q    <= tk_d;
    shift_q <= shift_d;
    zero_q  <= zero_d;
    sum_q   <= sum_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    best_q  <= best_d;
    bestv_q <= bestv_d;
    if (state_q == mlp_pkg::S_LSTORE) begin
      if (v_q > 0) begin
        hid_q[HIdxW'(h_wr_int)] <= v_q;
      end else begin
        hid_q[HIdxW'(h_wr_int)] <= prod_q[47:16];
      end
    end
    if (state_q == mlp_pkg::S_FIN && layer_q == 2'd2) begin
      z_q[cls] <= sat_v;
    end
    if (state_q == mlp_pkg::S_EXP_END) begin
      exp_q[cls] <= e_val;
    end
    if (state_q == mlp_pkg::S_DIV_END) begin
      quot_q[cls] <= quo_q[ExpW-1:0];
    end
  end

  // One result per cycle; probability saturates at full scale.
  assign result_valid_o = (state_q == mlp_pkg::S_OUT);
  assign class_index_o  = mlp_pkg::ClassW'(node_q);
  assign probability_o  = quot_q[cls][ExpW-1] ? '1 : quot_q[cls][mlp_pkg::ProbW-1:0];
  assign best_class_o   = mlp_pkg::ClassW'(best_q);
  assign last_o         = result_valid_o && node_last;
endmodule

// ===== src/mlp_checker.sv =====
// Port-level checker for mlp_inference_leaky_softmax and its bind statement.
// Depends on the top level's port list only.
module mlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy,
  input logic       result_valid_o,
  input logic [1:0] class_index_o,
  input logic       last_o
);
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy window");

  a_class_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o &&
      class_index_o == $past(class_index_o) + 2'd1)
    else $error("results not consecutive");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !busy) else $error("busy after last result");

  a_first_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> class_index_o == 2'd0)
    else $error("results do not start at class zero");
endmodule

bind mlp_inference_leaky_softmax mlp_checker u_mlp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .class_index_o  (class_index_o),
  .last_o         (last_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the perceptron inference block mlp_inference_leaky_softmax.
// Holds a bit-exact predictor of the network and softmax; depends on mlp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int WeightL2Base = mlp_pkg::InputNodes * mlp_pkg::HiddenOneNodes;
  localparam int WeightL3Base = WeightL2Base + mlp_pkg::HiddenOneNodes * mlp_pkg::HiddenTwoNodes;
  localparam int WeightTotal  = WeightL3Base + mlp_pkg::HiddenTwoNodes * mlp_pkg::OutputNodes;
  localparam int BiasTotal    = mlp_pkg::HiddenOneNodes + mlp_pkg::HiddenTwoNodes +
                                mlp_pkg::OutputNodes;
  localparam int CycleLimit   = 32_000_000;
  localparam int DrainCycles  = 40;
  localparam int MaxReported  = 10;

  // Table of 2^(-k/16) in units of 1/65536, used by the exp predictor.
  localparam longint unsigned Pow2Steps [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  typedef struct packed {
    logic [mlp_pkg::ClassW-1:0] class_index;
    logic [mlp_pkg::ProbW-1:0]  probability;
    logic [mlp_pkg::ClassW-1:0] best_class;
    logic                       last;
  } class_result_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  mlp_pkg::op_e                      op_i;
  logic [mlp_pkg::IndexW-1:0]        index_i;
  logic signed [mlp_pkg::ValueW-1:0] weight_value_i;
  logic [mlp_pkg::PixelW-1:0]        pixel_i;
  logic                              last_pixel_i;
  logic                              result_valid_o;
  logic [mlp_pkg::ClassW-1:0]        class_index_o;
  logic [mlp_pkg::ProbW-1:0]         probability_o;
  logic [mlp_pkg::ClassW-1:0]        best_class_o;
  logic                              last_o;

  // The predictor's own copy of the network stores.
  shortint signed model_weights [WeightTotal];
  shortint signed model_biases [BiasTotal];
  byte unsigned   model_pixels [mlp_pkg::InputNodes];

  class_result_t  expected_classes[$];
  int             mismatch_count;
  int             inference_count;
  int             sender_idle_pct;
  longint         cycle_count;

  mlp_inference_leaky_softmax DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .index_i        (index_i),
    .weight_value_i (weight_value_i),
    .pixel_i        (pixel_i),
    .last_pixel_i   (last_pixel_i),
    .result_valid_o (result_valid_o),
    .class_index_o  (class_index_o),
    .probability_o  (probability_o),
    .best_class_o   (best_class_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Weighted sum plus bias, shifted from Q.28 to Q.16 with floor, then clamped to 32 bits.
  function automatic int signed node_sum(longint signed acc, shortint signed bias);
    longint signed v;
    v = (acc + longint'(bias) * 65536) >>> 12;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  // Leaky ReLU with a slope of 0.05 in Q0.16; the arithmetic shift gives floor.
  function automatic int signed leaky_relu(int signed v);
    if (v > 0) return v;
    return int'((longint'(v) * mlp_pkg::LeakQ16) >>> 16);
  endfunction

  // exp(-d) for a Q.16 distance d: base-2 split, table step and linear interpolation.
  function automatic longint unsigned softmax_exp(longint unsigned d);
    longint unsigned t, n, f, k, r, m;
    t = (d * mlp_pkg::Log2eQ16) >> 16;
    n = t >> 16;
    f = t & 64'hFFFF;
    k = f >> 12;
    r = f & 64'hFFF;
    if (n >= 17) return 0;
    m = Pow2Steps[k] - (((Pow2Steps[k] - Pow2Steps[k + 1]) * r) >> 12);
    return m >> n;
  endfunction

  // Runs the whole network on the stored pixels and queues one result per class.
  task automatic predict_classes();
    int signed       hidden_one [mlp_pkg::HiddenOneNodes];
    int signed       hidden_two [mlp_pkg::HiddenTwoNodes];
    int signed       logits [mlp_pkg::OutputNodes];
    longint unsigned exps [mlp_pkg::OutputNodes];
    longint unsigned quotients [mlp_pkg::OutputNodes];
    longint unsigned exp_sum;
    longint signed   acc;
    int signed       top_logit;
    int              best;
    class_result_t   res;
    for (int i = 0; i < mlp_pkg::HiddenOneNodes; i++) begin
      acc = 0;
      for (int j = 0; j < mlp_pkg::InputNodes; j++) begin
        acc += longint'(model_pixels[j]) * 257 *
               model_weights[j * mlp_pkg::HiddenOneNodes + i];
      end
      hidden_one[i] = leaky_relu(node_sum(acc, model_biases[i]));
    end
    for (int i = 0; i < mlp_pkg::HiddenTwoNodes; i++) begin
      acc = 0;
      for (int j = 0; j < mlp_pkg::HiddenOneNodes; j++) begin
        acc += longint'(hidden_one[j]) *
               model_weights[WeightL2Base + j * mlp_pkg::HiddenTwoNodes + i];
      end
      hidden_two[i] = leaky_relu(node_sum(acc, model_biases[mlp_pkg::HiddenOneNodes + i]));
    end
    for (int i = 0; i < mlp_pkg::OutputNodes; i++) begin
      acc = 0;
      for (int j = 0; j < mlp_pkg::HiddenTwoNodes; j++) begin
        acc += longint'(hidden_two[j]) *
               model_weights[WeightL3Base + j * mlp_pkg::OutputNodes + i];
      end
      logits[i] = node_sum(acc, model_biases[mlp_pkg::HiddenOneNodes +
                                             mlp_pkg::HiddenTwoNodes + i]);
    end
    top_logit = logits[0];
    for (int i = 1; i < mlp_pkg::OutputNodes; i++) begin
      if (logits[i] > top_logit) top_logit = logits[i];
    end
    exp_sum = 0;
    for (int i = 0; i < mlp_pkg::OutputNodes; i++) begin
      exps[i] = softmax_exp(longint'(top_logit) - longint'(logits[i]));
      exp_sum += exps[i];
    end
    // The best class is judged on the quotients before saturation, lowest index on ties.
    best = 0;
    for (int i = 0; i < mlp_pkg::OutputNodes; i++) begin
      quotients[i] = (exps[i] << 16) / exp_sum;
      if (quotients[i] > quotients[best]) best = i;
    end
    for (int i = 0; i < mlp_pkg::OutputNodes; i++) begin
      res.class_index = mlp_pkg::ClassW'(i);
      res.probability = (quotients[i] > 65535) ? 16'hFFFF : mlp_pkg::ProbW'(quotients[i]);
      res.best_class  = mlp_pkg::ClassW'(best);
      res.last        = (i == mlp_pkg::OutputNodes - 1);
      expected_classes.push_back(res);
    end
    inference_count++;
  endtask

  // Applies an accepted request to the predictor's stores.
  task automatic predict_request(mlp_pkg::op_e op, int idx, shortint signed value,
                                 byte unsigned pix, bit last_pix);
    case (op)
      mlp_pkg::OP_WEIGHT: begin
        if (idx < WeightTotal) model_weights[idx] = value;
      end
      mlp_pkg::OP_BIAS: begin
        if (idx < BiasTotal) model_biases[idx] = value;
      end
      mlp_pkg::OP_PIXEL: begin
        if (idx < mlp_pkg::InputNodes) model_pixels[idx] = pix;
        if (last_pix) predict_classes();
      end
      default: ;
    endcase
  endtask

  // Sends one request. It is entered and left just after a rising edge; start stays high on
  // return, so a back-to-back request never lowers and raises it in the same step.
  task automatic send_request(mlp_pkg::op_e op, int idx, shortint signed value,
                              byte unsigned pix, bit last_pix);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    op_i           <= op;
    index_i        <= mlp_pkg::IndexW'(idx);
    weight_value_i <= value;
    pixel_i        <= pix;
    last_pixel_i   <= last_pix;
    // The request is taken at the first edge where busy was low.
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(op, idx, value, pix, last_pix);
  endtask

  // Lets the block finish every pending inference. Start drops first so that the last
  // request is not taken again.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Fills every weight, bias and pixel so that no later read hits an unwritten entry.
  task automatic test_network_load();
    sender_idle_pct = 0;
    for (int w = 0; w < WeightTotal; w++) begin
      send_request(mlp_pkg::OP_WEIGHT, w, shortint'(int'($urandom_range(0, 1536)) - 768),
                   8'd0, 1'b0);
    end
    for (int b = 0; b < BiasTotal; b++) begin
      send_request(mlp_pkg::OP_BIAS, b, shortint'(int'($urandom_range(0, 4096)) - 2048),
                   8'd0, 1'b0);
    end
    for (int p = 0; p < mlp_pkg::InputNodes; p++) begin
      send_request(mlp_pkg::OP_PIXEL, p, 16'sd0, byte'($urandom_range(255)),
                   p == mlp_pkg::InputNodes - 1);
    end
    wait_for_results();
  endtask

  // Field extremes, ignored requests and out-of-range addresses.
  task automatic test_corner_requests();
    // Extreme weight and bias values and extreme pixel bytes, then an inference.
    send_request(mlp_pkg::OP_WEIGHT, 0, 16'sh7FFF, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_WEIGHT, WeightTotal - 1, -16'sh8000, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_BIAS, BiasTotal - 1, 16'sh7FFF, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_BIAS, 0, -16'sh8000, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_PIXEL, 0, 16'sd0, 8'd255, 1'b0);
    send_request(mlp_pkg::OP_PIXEL, mlp_pkg::InputNodes - 1, 16'sd0, 8'd0, 1'b1);
    // The last pixel mark only counts with the pixel operation.
    send_request(mlp_pkg::OP_WEIGHT, 5, 16'sh0123, 8'd0, 1'b1);
    send_request(mlp_pkg::OP_BIAS, 3, -16'sh0100, 8'd0, 1'b1);
    // The unused operation is ignored entirely, even with the last pixel mark.
    send_request(mlp_pkg::OP_NONE, 8191, -16'sh5555, 8'hAA, 1'b1);
    // Out-of-range addresses are dropped.
    send_request(mlp_pkg::OP_WEIGHT, WeightTotal, 16'sh7FFF, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_WEIGHT, 8191, -16'sh8000, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_BIAS, BiasTotal, 16'sh7FFF, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_BIAS, 8191, 16'sh7FFF, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_PIXEL, 8191, 16'sd0, 8'd255, 1'b0);
    // A dropped pixel still starts the network when it carries the mark.
    send_request(mlp_pkg::OP_PIXEL, mlp_pkg::InputNodes, 16'sd0, 8'd128, 1'b1);
    // A large bias pushes one logit far ahead of the others.
    send_request(mlp_pkg::OP_BIAS, BiasTotal - 2, 16'sh7FFF, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_BIAS, BiasTotal - 1, -16'sh8000, 8'd0, 1'b0);
    send_request(mlp_pkg::OP_PIXEL, 200, 16'sd0, 8'd77, 1'b1);
    // Output biases cleared to zero, then another inference; a tie goes to the lowest class.
    for (int b = mlp_pkg::HiddenOneNodes + mlp_pkg::HiddenTwoNodes; b < BiasTotal; b++) begin
      send_request(mlp_pkg::OP_BIAS, b, 16'sh0000, 8'd0, 1'b0);
    end
    send_request(mlp_pkg::OP_PIXEL, 1, 16'sd0, 8'd0, 1'b1);
    wait_for_results();
  endtask

  // One random request, mostly pixels and weight updates with in-range addresses.
  // Returns 1 when the request changes the block's state or starts an inference.
  task automatic send_random_request(output bit counted);
    int   kind, idx;
    shortint signed value;
    bit   last_pix;
    kind = $urandom_range(99);
    value = ($urandom_range(9) == 0) ? shortint'($urandom) :
            shortint'(int'($urandom_range(0, 2048)) - 1024);
    counted = 1'b1;
    if (kind < 50) begin
      idx = ($urandom_range(19) == 0) ? $urandom_range(mlp_pkg::InputNodes, 8191) :
            $urandom_range(mlp_pkg::InputNodes - 1);
      last_pix = ($urandom_range(12) == 0);
      counted = (idx < mlp_pkg::InputNodes) || last_pix;
      send_request(mlp_pkg::OP_PIXEL, idx, shortint'($urandom), byte'($urandom), last_pix);
    end else if (kind < 85) begin
      idx = ($urandom_range(19) == 0) ? $urandom_range(WeightTotal, 8191) :
            $urandom_range(WeightTotal - 1);
      counted = idx < WeightTotal;
      send_request(mlp_pkg::OP_WEIGHT, idx, value, byte'($urandom), 1'($urandom_range(1)));
    end else if (kind < 95) begin
      idx = ($urandom_range(9) == 0) ? $urandom_range(BiasTotal, 8191) :
            $urandom_range(BiasTotal - 1);
      counted = idx < BiasTotal;
      send_request(mlp_pkg::OP_BIAS, idx, value, byte'($urandom), 1'($urandom_range(1)));
    end else begin
      counted = 1'b0;
      send_request(mlp_pkg::OP_NONE, $urandom_range(8191), shortint'($urandom),
                   byte'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // A random phase at one sender idle rate, run until enough requests and inferences are done.
  task automatic test_random_phase(int idle_pct, int item_goal, int inference_goal);
    int sent, first_inference;
    bit counted;
    sender_idle_pct = idle_pct;
    sent = 0;
    first_inference = inference_count;
    while (sent < item_goal || inference_count - first_inference < inference_goal) begin
      send_random_request(counted);
      if (counted) sent++;
    end
    wait_for_results();
  endtask

  // Compares each result, in class order, with the oldest prediction.
  always @(posedge clk_i) begin
    class_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_classes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("unexpected result: class %0d prob %0d best %0d last %0d",
                   class_index_o, probability_o, best_class_o, last_o);
        end
      end else begin
        want = expected_classes.pop_front();
        if (want != {class_index_o, probability_o, best_class_o, last_o}) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("result mismatch: expected class %0d prob %0d best %0d last %0d",
                     want.class_index, want.probability, want.best_class, want.last);
            $display("                 actual   class %0d prob %0d best %0d last %0d",
                     class_index_o, probability_o, best_class_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatch_count  = 0;
    inference_count = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    foreach (model_biases[b]) model_biases[b] = 0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    op_i           <= mlp_pkg::OP_NONE;
    index_i        <= '0;
    weight_value_i <= '0;
    pixel_i        <= '0;
    last_pixel_i   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_network_load();
    test_corner_requests();
    // Idle rates: none, heavy, none again, light; at least 105 counted requests and 8 inferences each.
    test_random_phase(0, 105, 8);
    test_random_phase(64, 105, 8);
    test_random_phase(0, 105, 8);
    test_random_phase(10, 105, 8);

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
